@@ hw/rtl/index_allocator_free_list_defines.svh @@
// Assertion macros for the index allocator RTL, included by ixa_back.
// Depends on nothing; files that check their own logic include it by name.
`ifndef INDEX_ALLOCATOR_FREE_LIST_DEFINES_SVH
`define INDEX_ALLOCATOR_FREE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define IXA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that must be accompanied by a consequent in the same cycle.
`define IXA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define IXA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define IXA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ixa_pkg.sv @@
// Shared types, codes and constants of the index allocator.
// Used by the front end, back end and top level; depends on nothing.
package ixa_pkg;

  // Default pool capacity and field widths of the channels.
  localparam int ENTRIES_DEFAULT = 64;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int OP_W = 2;

  // Pool size register value after reset.
  localparam int CFG_RESET = 64;

  // Depth of the command queue and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_ALLOCATE       = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE        = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE_OLDEST = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE_ALL    = 2'd3;

  // Decoded command kind, one bit per operation.
  typedef enum logic [3:0] {
    CMD_ALLOC       = 4'b0001,
    CMD_RELEASE     = 4'b0010,
    CMD_RELEASE_OLD = 4'b0100,
    CMD_RELEASE_ALL = 4'b1000
  } cmd_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NONE_USED = 2'd3
  } status_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t            kind;
    logic [INDEX_W-1:0]   index;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic [INDEX_W-1:0]   result_index;
    status_t              status;
    logic [COUNT_W-1:0]   used_count;
  } result_t;

endpackage

@@ hw/rtl/ixa_fifo.sv @@
// Small first-in first-out queue with full and empty flags.
// Generic storage used for the command queue and the result queue.
module ixa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == FW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Storage is written at the write pointer on every accepted transfer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers wrap at the depth; the fill level tracks both sides.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/ixa_front.sv @@
// Front end of the index allocator: decodes incoming operations and queues them.
// Depends on ixa_pkg and ixa_fifo.
module ixa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ixa_pkg::OP_W-1:0]    operation,
  input  logic [ixa_pkg::INDEX_W-1:0] index,
  output logic                        cmd_empty,
  input  logic                        cmd_pop,
  output ixa_pkg::cmd_t               cmd
);

  localparam int CmdW = $bits(ixa_pkg::cmd_t);

  ixa_pkg::cmd_t   cmd_in;
  logic [CmdW-1:0] cmd_vec;

  // Classify the operation code into a one-hot command kind.
  always_comb begin
    cmd_in.index = index;
    unique case (operation)
      ixa_pkg::OP_ALLOCATE:       cmd_in.kind = ixa_pkg::CMD_ALLOC;
      ixa_pkg::OP_RELEASE:        cmd_in.kind = ixa_pkg::CMD_RELEASE;
      ixa_pkg::OP_RELEASE_OLDEST: cmd_in.kind = ixa_pkg::CMD_RELEASE_OLD;
      default:                    cmd_in.kind = ixa_pkg::CMD_RELEASE_ALL;
    endcase
  end

  // Command queue that decouples the input side from the back end.
  ixa_fifo #(
    .WIDTH (CmdW),
    .DEPTH (ixa_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_vec)
  );

  assign cmd = cmd_vec;

endmodule

@@ hw/rtl/ixa_back.sv @@
// Back end of the index allocator: link memories, list pointers and the
// three-step sequencer for each command. Depends on ixa_pkg and the defines file.
`include "index_allocator_free_list_defines.svh"

module ixa_back #(
  parameter int ENTRIES = ixa_pkg::ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  ixa_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ixa_pkg::COUNT_W-1:0] cfg_data,
  output logic                        res_push,
  output ixa_pkg::result_t            res,
  input  logic                        res_full
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int PW   = $clog2(ENTRIES + 1);
  localparam int IdxW = ixa_pkg::INDEX_W;
  localparam int CntW = ixa_pkg::COUNT_W;
  localparam int CW   = (PW > IdxW) ? PW : IdxW;
  localparam int SW   = (PW > CntW) ? PW : CntW;
  localparam int PoolInit = (ENTRIES < ixa_pkg::CFG_RESET) ? ENTRIES : ixa_pkg::CFG_RESET;
  localparam logic [PW-1:0]   Nil      = PW'(ENTRIES);
  localparam logic [PW-1:0]   PoolRst  = PW'(PoolInit);
  localparam logic [CntW-1:0] CfgReset = CntW'(ixa_pkg::CFG_RESET);

  typedef enum logic [2:0] {
    S_ISSUE = 3'b001,
    S_EXEC  = 3'b010,
    S_FIX   = 3'b100
  } state_t;

  state_t state, state_next;

  // List pointers; the free list is a stack of released entries above a
  // watermark of entries never handed out since the last rebuild.
  logic [PW-1:0]   free_head, free_head_next;
  logic [PW-1:0]   fresh, fresh_next;
  logic [PW-1:0]   used_head, used_head_next;
  logic [PW-1:0]   used_tail, used_tail_next;
  logic [PW-1:0]   count, count_next;
  logic [PW-1:0]   pool_size, pool_size_next;
  logic [CntW-1:0] entries_in_use;

  // Command in flight.
  ixa_pkg::cmd_kind_t cur_kind;
  logic [IW-1:0]      cur_n;
  logic               cur_from_stack;
  logic               cur_in_range;
  logic [IW-1:0]      n_sel;
  logic [PW-1:0]      n_ptr;
  logic               take;

  // Second write of a command, done in the last step.
  logic          fix_next_en, fix_prev_en;
  logic [IW-1:0] fix_addr;
  logic [PW-1:0] fix_data;
  logic          fix_next_set, fix_prev_set;
  logic [IW-1:0] fix_addr_set;
  logic [PW-1:0] fix_data_set;

  // Link and flag memories.
  logic [PW-1:0] next_mem [ENTRIES];
  logic [PW-1:0] prev_mem [ENTRIES];
  logic          flag_mem [ENTRIES];
  logic [PW-1:0] next_q, prev_q;
  logic          flag_q;
  logic          next_we, prev_we, flag_we;
  logic [IW-1:0] next_waddr, prev_waddr, flag_waddr;
  logic [PW-1:0] next_wdata, prev_wdata;
  logic          flag_wdata;

  // Result fields.
  logic              res_ok;
  ixa_pkg::status_t  res_status;

  // Pool size from the register, saturated to the supported range.
  logic [SW-1:0] cfg_wide;
  logic [PW-1:0] pool_from_cfg;

  assign cfg_ready = 1'b1;
  assign cfg_wide  = SW'(entries_in_use);
  assign pool_from_cfg = (cfg_wide == '0)            ? PW'(1) :
                         (cfg_wide > SW'(ENTRIES))   ? Nil    : PW'(cfg_wide);

  // A command is taken in the issue step when one is queued and the result queue has room for its result.
  assign take    = (state == S_ISSUE) && !cmd_empty && !res_full;
  assign cmd_pop = take;
  assign n_ptr   = PW'(cur_n);

  // Select the entry whose links the command reads.
  always_comb begin
    unique case (cmd.kind)
      ixa_pkg::CMD_ALLOC:
        n_sel = (free_head != Nil) ? free_head[IW-1:0] : fresh[IW-1:0];
      ixa_pkg::CMD_RELEASE:     n_sel = IW'(cmd.index);
      ixa_pkg::CMD_RELEASE_OLD: n_sel = used_tail[IW-1:0];
      default:                  n_sel = '0;
    endcase
  end

  // Memory ports: one registered read in the issue step, at most one write in each later step.
  always_ff @(posedge clk) begin
    if (take) begin
      next_q <= next_mem[n_sel];
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_q <= prev_mem[n_sel];
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      flag_q <= flag_mem[n_sel];
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // Sequencer: issue reads, execute the list update, finish the second write.
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    fresh_next     = fresh;
    used_head_next = used_head;
    used_tail_next = used_tail;
    count_next     = count;
    pool_size_next = pool_size;
    next_we        = 1'b0;
    next_waddr     = cur_n;
    next_wdata     = free_head;
    prev_we        = 1'b0;
    prev_waddr     = cur_n;
    prev_wdata     = Nil;
    flag_we        = 1'b0;
    flag_waddr     = cur_n;
    flag_wdata     = 1'b0;
    fix_next_set   = 1'b0;
    fix_prev_set   = 1'b0;
    fix_addr_set   = '0;
    fix_data_set   = '0;
    res_ok         = 1'b0;
    res_status     = ixa_pkg::ST_OK;
    unique case (state)
      S_ISSUE: begin
        if (take) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIX;
        unique case (cur_kind) inside
          ixa_pkg::CMD_ALLOC: begin
            if (count >= pool_size) begin
              res_status = ixa_pkg::ST_EXHAUSTED;
            end else begin
              // New head of the used list; its old head gets a back link next.
              res_ok     = 1'b1;
              next_we    = 1'b1;
              next_wdata = used_head;
              prev_we    = 1'b1;
              prev_wdata = Nil;
              flag_we    = 1'b1;
              flag_wdata = 1'b1;
              if (cur_from_stack) begin
                free_head_next = next_q;
              end else begin
                fresh_next = fresh + 1'b1;
              end
              used_head_next = n_ptr;
              if (used_head == Nil) begin
                used_tail_next = n_ptr;
              end
              count_next   = count + 1'b1;
              fix_prev_set = (used_head != Nil);
              fix_addr_set = used_head[IW-1:0];
              fix_data_set = n_ptr;
            end
          end
          ixa_pkg::CMD_RELEASE, ixa_pkg::CMD_RELEASE_OLD: begin
            if ((cur_kind == ixa_pkg::CMD_RELEASE) ? (cur_in_range && flag_q)
                                                   : (count != '0)) begin
              // Unlink from the used list and push onto the free stack.
              res_ok     = 1'b1;
              next_we    = 1'b1;
              next_wdata = free_head;
              flag_we    = 1'b1;
              flag_wdata = 1'b0;
              if (next_q != Nil) begin
                prev_we    = 1'b1;
                prev_waddr = next_q[IW-1:0];
                prev_wdata = prev_q;
              end else begin
                used_tail_next = prev_q;
              end
              if (prev_q == Nil) begin
                used_head_next = next_q;
              end
              free_head_next = n_ptr;
              count_next     = count - 1'b1;
              fix_next_set   = (prev_q != Nil);
              fix_addr_set   = prev_q[IW-1:0];
              fix_data_set   = next_q;
            end else begin
              res_status = (cur_kind == ixa_pkg::CMD_RELEASE) ? ixa_pkg::ST_BAD_INDEX
                                                              : ixa_pkg::ST_NONE_USED;
            end
          end
          default: begin
            // Rebuild: both lists restart and the pool size is reloaded.
            free_head_next = Nil;
            fresh_next     = '0;
            used_head_next = Nil;
            used_tail_next = Nil;
            count_next     = '0;
            pool_size_next = pool_from_cfg;
          end
        endcase
      end
      S_FIX: begin
        state_next = S_ISSUE;
        next_we    = fix_next_en;
        next_waddr = fix_addr;
        next_wdata = fix_data;
        prev_we    = fix_prev_en;
        prev_waddr = fix_addr;
        prev_wdata = fix_data;
      end
      default: begin
        state_next = S_ISSUE;
      end
    endcase
  end

  // Result of the command, pushed in the execute step.
  assign res_push         = (state == S_EXEC);
  assign res.result_index = res_ok ? IdxW'(cur_n) : '0;
  assign res.status       = res_status;
  assign res.used_count   = CntW'(count_next);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_ISSUE;
      free_head      <= Nil;
      fresh          <= '0;
      used_head      <= Nil;
      used_tail      <= Nil;
      count          <= '0;
      pool_size      <= PoolRst;
      entries_in_use <= CfgReset;
      fix_next_en    <= 1'b0;
      fix_prev_en    <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      used_head <= used_head_next;
      used_tail <= used_tail_next;
      count     <= count_next;
      pool_size <= pool_size_next;
      if (cfg_valid && cfg_ready) begin
        entries_in_use <= cfg_data;
      end
      if (state == S_EXEC) begin
        fix_next_en <= fix_next_set;
        fix_prev_en <= fix_prev_set;
      end
    end
  end

  // Command and second-write payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      cur_kind       <= cmd.kind;
      cur_n          <= n_sel;
      cur_from_stack <= (free_head != Nil);
      cur_in_range   <= (CW'(cmd.index) < CW'(fresh));
    end
    if (state == S_EXEC) begin
      fix_addr <= fix_addr_set;
      fix_data <= fix_data_set;
    end
  end

  // List bookkeeping checks.
  `IXA_ASSERT_ALWAYS(a_count_in_pool, clk, rst, count <= pool_size, "count exceeds pool size")
  `IXA_ASSERT_ALWAYS(a_fresh_in_pool, clk, rst, fresh <= pool_size, "watermark beyond pool")
  `IXA_ASSERT_ALWAYS(a_head_count, clk, rst, (used_head == Nil) == (count == '0), "bad head")
  `IXA_ASSERT_ALWAYS(a_tail_count, clk, rst, (used_tail == Nil) == (count == '0), "bad tail")
  `IXA_ASSERT_IMPLIES(a_free_stack, clk, rst, free_head != Nil, free_head < fresh, "bad stack")

endmodule

@@ hw/rtl/index_allocator_free_list.sv @@
// Top level of the free-list index allocator.
// Depends on ixa_pkg, ixa_front, ixa_back and ixa_fifo.
//
// Usage:
//   Operations enter through a queue port: an item transfers when push is high
//   and full is low. operation selects allocate, release index, release oldest
//   or release all; index is used only by release index.
//   Results leave through a queue port: the oldest result is shown while empty
//   is low and transfers when pop is high. Each operation gives one result with
//   the index, a status and the number of indices in use afterwards.
//   The pool size register is written through cfg_valid/cfg_ready/cfg_data and
//   takes effect on the next release all; reset restores the default size.
// Sequencing:
//   The back end takes each operation from the command queue and pushes its
//   result in the execute step of a three-step read, update, second-write
//   sequence on the single-port link memories; it takes no new operation
//   until its last step ends. Release all restarts the lists from a watermark.
// Reset and stall:
//   Reset empties both queues and restarts the lists with no clearing pass. A
//   receiver that stops popping fills the two-entry result queue, then the
//   back end waits and the command queue raises full.
module index_allocator_free_list #(
  parameter int ENTRIES = ixa_pkg::ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ixa_pkg::OP_W-1:0]    operation,
  input  logic [ixa_pkg::INDEX_W-1:0] index,
  output logic                        empty,
  input  logic                        pop,
  output logic [ixa_pkg::INDEX_W-1:0] result_index,
  output logic [1:0]                  status,
  output logic [ixa_pkg::COUNT_W-1:0] used_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ixa_pkg::COUNT_W-1:0] cfg_data
);

  localparam int ResW = $bits(ixa_pkg::result_t);

  logic              cmd_empty;
  logic              cmd_pop;
  ixa_pkg::cmd_t     cmd;
  logic              res_push;
  logic              res_full;
  ixa_pkg::result_t  res_in;
  ixa_pkg::result_t  res_out;
  logic [ResW-1:0]   res_vec;

  // Decode and queue incoming operations.
  ixa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .index     (index),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Carry out each operation on the lists.
  ixa_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Result queue that holds finished results until they are popped.
  ixa_fifo #(
    .WIDTH (ResW),
    .DEPTH (ixa_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_vec)
  );

  assign res_out      = res_vec;
  assign result_index = res_out.result_index;
  assign status       = res_out.status;
  assign used_count   = res_out.used_count;

endmodule
